[rtl/lca_pkg.sv]
// Shared constants, types and the B3/S23 rule for the life step block.
package lca_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int MIN_SIZE    = 3;

	localparam int SIZE_W    = 11;                     // grid_width / grid_height registers
	localparam int POS_W     = SIZE_W + 1;             // position math, room for +1
	localparam int COL_W     = $clog2(MAX_COLUMNS);    // line store address
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int OUT_W     = 10;                     // out_column / out_row ports
	localparam int CFG_IDX_W = 2;
	localparam int WIN_W     = 9;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_GRID_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_GRID_HEIGHT = cfg_idx_t'(1);

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [POS_W-1:0]  pos_t;

	// one line store entry: bit 0 is the row two above, bit 1 the row just above
	typedef logic [1:0] line_t;

	function automatic size_t clamp_size(input size_t v, input size_t hi);
		size_t r;
		if (v < size_t'(MIN_SIZE))
			r = size_t'(MIN_SIZE);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

	// window: three columns of three bits, bit 4 is the centre cell
	function automatic logic next_state(input logic [WIN_W-1:0] win);
		logic [3:0] nb;
		logic       res;
		nb = '0;
		for (int i = 0; i < WIN_W; i++) begin
			if (i != 4)
				nb = nb + 4'(win[i]);
		end
		if (win[4])
			res = (nb == 4'd2) || (nb == 4'd3);
		else
			res = (nb == 4'd3);
		return res;
	endfunction

endpackage

[rtl/life_cellular_automaton_step_top.sv]
// Game of Life B3/S23 generation step over a raster cell stream with a line store of two rows.
// A result forms as its completing cell leaves stage 1 and waits in the output register.
// Throughput: one cell per cycle unless out_stall holds a result; the line store (one read
//   port used at accept, one write port used as the cell leaves stage 1, with a forwarding
//   path) and the output register set that rate. Reset: asynchronous, active low; then a
//   sweep of all 1024 entries zeroes the line store, in_stall high (config writes taken).
module life_cellular_automaton_step_top
	import lca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cell_alive,
	input  logic                 frame_start,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 next_alive,
	output logic [OUT_W-1:0]     out_column,
	output logic [OUT_W-1:0]     out_row,
	output logic                 frame_last
);

	// configuration
	size_t grid_width_q, grid_height_q;
	size_t w_eff, h_eff;

	// position of the next incoming cell
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// line store clearing sweep
	logic             clearing_q;
	logic [COL_W-1:0] clr_q;

	// line store
	line_t            line_mem [MAX_COLUMNS];
	logic             mem_we;
	logic [COL_W-1:0] mem_wa;
	line_t            mem_wd;

	// stage 1: accepted cell with its line store data
	logic             s1_valid_q;
	logic             alive_s1;
	logic [COL_W-1:0] addr_s1;
	logic             prod_s1;
	logic             last_s1;
	logic             hit_s1;
	line_t            byp_s1;
	line_t            rd_s1;
	logic [OUT_W-1:0] ocol_s1;
	logic [OUT_W-1:0] orow_s1;

	logic [WIN_W-1:0] window_q;
	logic [WIN_W-1:0] win_new;
	line_t            line_eff;
	line_t            wr_line;
	logic             s1_free;

	// output register
	logic             out_valid_q;
	logic             next_alive_q;
	logic [OUT_W-1:0] out_column_q;
	logic [OUT_W-1:0] out_row_q;
	logic             frame_last_q;

	logic             in_acc;
	pos_t             c0, r0, c1, r1, r2, cn, rn;
	pos_t             w_pos, h_pos;
	logic             prod_new, last_new, hit_new;
	logic [COL_W-1:0] addr_new;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= size_t'(MAX_COLUMNS);
			grid_height_q <= size_t'(MAX_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_size(grid_width_q, size_t'(MAX_COLUMNS));
	assign h_eff = clamp_size(grid_height_q, size_t'(MAX_ROWS));
	assign w_pos = pos_t'(w_eff);
	assign h_pos = pos_t'(h_eff);

	// position of the incoming cell, then of the one after it
	always_comb begin
		c0 = frame_start ? '0 : pos_t'(col_q);
		r0 = frame_start ? '0 : pos_t'(row_q);
		if (c0 >= w_pos) begin
			c1 = '0;
			r1 = r0 + pos_t'(1);
		end else begin
			c1 = c0;
			r1 = r0;
		end
		r2 = (r1 >= h_pos) ? '0 : r1;
		cn = c1 + pos_t'(1);
		rn = r2;
		if (cn >= w_pos) begin
			cn = '0;
			rn = r2 + pos_t'(1);
			if (rn >= h_pos)
				rn = '0;
		end
	end

	assign addr_new = c1[COL_W-1:0];
	assign prod_new = (c1 >= pos_t'(2)) && (r2 >= pos_t'(2));
	assign last_new = (c1 == w_pos - pos_t'(1)) && (r2 == h_pos - pos_t'(1));
	// the cell in stage 1 writes this entry at the same edge the new cell reads it
	assign hit_new  = s1_valid_q && (addr_s1 == addr_new);

	assign s1_free  = !s1_valid_q || !prod_s1 || !out_valid_q || !out_stall;
	assign in_stall = clearing_q || !s1_free;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			col_q <= cn[COL_W-1:0];
			row_q <= rn[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + COL_W'(1);
			if (clr_q == COL_W'(MAX_COLUMNS - 1))
				clearing_q <= 1'b0;
		end
	end

	// stage 1 combinational work
	assign line_eff = hit_s1 ? byp_s1 : rd_s1;
	assign wr_line  = {alive_s1, line_eff[1]};
	assign win_new  = {alive_s1, line_eff[1], line_eff[0], window_q[WIN_W-1:3]};

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s1;
		mem_wd = wr_line;
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (s1_valid_q && s1_free) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_wa] <= mem_wd;
		if (in_acc)
			rd_s1 <= line_mem[addr_new];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			alive_s1 <= cell_alive;
			addr_s1  <= addr_new;
			prod_s1  <= prod_new;
			last_s1  <= last_new;
			hit_s1   <= hit_new;
			byp_s1   <= wr_line;
			ocol_s1  <= OUT_W'(c1 - pos_t'(1));
			orow_s1  <= OUT_W'(r2 - pos_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_valid_q && s1_free) begin
			window_q <= win_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_free && prod_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_free && prod_s1) begin
			next_alive_q <= next_state(win_new);
			out_column_q <= ocol_s1;
			out_row_q    <= orow_s1;
			frame_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_alive = next_alive_q;
	assign out_column = out_column_q;
	assign out_row    = out_row_q;
	assign frame_last = frame_last_q;

`ifndef SYNTHESIS
	// the store sweep and real traffic never overlap
	a_no_s1_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s1_valid_q)
		else $error("cell in flight during line store sweep");

	// border cells are never emitted
	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_column != '0) && (out_row != '0))
		else $error("border cell emitted");

	// last-of-frame sits on the last interior column
	a_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (pos_t'(out_column) + pos_t'(2) == w_pos))
		else $error("frame_last off the last interior column");

	// an accepted cell always lands in stage 1
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q)
		else $error("accepted cell lost before stage 1");

	// the sweep ends only after covering every entry
	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> (clr_q == '0))
		else $error("line store sweep ended early");
`endif

endmodule
